// ===== rtl/c6502_pkg.sv =====
// Package with the operation codes, decode table and shared types of the 6502 execute unit.
`default_nettype none
package c6502_pkg;

	typedef enum logic [5:0] {
		OP_ILL, OP_SYS, OP_NOP, OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_SBC, OP_CMP, OP_CPX,
		OP_CPY, OP_BIT, OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY,
		OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_ASLA, OP_LSRA, OP_ROLA, OP_RORA,
		OP_INC, OP_DEC, OP_INX, OP_INY, OP_DEX, OP_DEY,
		OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TSX, OP_TXS,
		OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED,
		OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ
	} op_t;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_ILLEGAL = 2'd1;
	localparam logic [1:0] ST_SYSTEM = 2'd2;

	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] FLAGS_RESET = 8'h24;

	// Decoded beat handed from the front end to the back end.
	typedef struct packed {
		op_t         op;
		logic [7:0]  operand;
		logic [15:0] next_pc;
	} dec_beat_t;

	// Opcode decode table.
	function automatic op_t decode_op(input logic [7:0] opc);
		op_t r;
		r = OP_ILL;
		unique case (opc)
			8'h00, 8'h08, 8'h20, 8'h28, 8'h40, 8'h48, 8'h4C, 8'h60, 8'h68, 8'h6C:
				r = OP_SYS;
			8'h04, 8'h0C, 8'h14, 8'h1A, 8'h1C, 8'h34, 8'h3A, 8'h3C, 8'h44, 8'h54,
			8'h5A, 8'h5C, 8'h64, 8'h74, 8'h7A, 8'h7C, 8'h80, 8'h82, 8'h89, 8'hC2,
			8'hD4, 8'hDA, 8'hDC, 8'hE2, 8'hEA, 8'hF4, 8'hFA, 8'hFC:
				r = OP_NOP;
			8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: r = OP_ORA;
			8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: r = OP_AND;
			8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: r = OP_EOR;
			8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: r = OP_ADC;
			8'hE1, 8'hE5, 8'hE9, 8'hEB, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD: r = OP_SBC;
			8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: r = OP_CMP;
			8'hE0, 8'hE4, 8'hEC: r = OP_CPX;
			8'hC0, 8'hC4, 8'hCC: r = OP_CPY;
			8'h24, 8'h2C: r = OP_BIT;
			8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: r = OP_LDA;
			8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: r = OP_LDX;
			8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: r = OP_LDY;
			8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: r = OP_STA;
			8'h86, 8'h8E, 8'h96: r = OP_STX;
			8'h84, 8'h8C, 8'h94: r = OP_STY;
			8'h06, 8'h0E, 8'h16, 8'h1E: r = OP_ASL;
			8'h46, 8'h4E, 8'h56, 8'h5E: r = OP_LSR;
			8'h26, 8'h2E, 8'h36, 8'h3E: r = OP_ROL;
			8'h66, 8'h6E, 8'h76, 8'h7E: r = OP_ROR;
			8'h0A: r = OP_ASLA;
			8'h4A: r = OP_LSRA;
			8'h2A: r = OP_ROLA;
			8'h6A: r = OP_RORA;
			8'hE6, 8'hEE, 8'hF6, 8'hFE: r = OP_INC;
			8'hC6, 8'hCE, 8'hD6, 8'hDE: r = OP_DEC;
			8'hE8: r = OP_INX;
			8'hC8: r = OP_INY;
			8'hCA: r = OP_DEX;
			8'h88: r = OP_DEY;
			8'hAA: r = OP_TAX;
			8'hA8: r = OP_TAY;
			8'h8A: r = OP_TXA;
			8'h98: r = OP_TYA;
			8'hBA: r = OP_TSX;
			8'h9A: r = OP_TXS;
			8'h18: r = OP_CLC;
			8'h38: r = OP_SEC;
			8'h58: r = OP_CLI;
			8'h78: r = OP_SEI;
			8'hB8: r = OP_CLV;
			8'hD8: r = OP_CLD;
			8'hF8: r = OP_SED;
			8'h10: r = OP_BPL;
			8'h30: r = OP_BMI;
			8'h50: r = OP_BVC;
			8'h70: r = OP_BVS;
			8'h90: r = OP_BCC;
			8'hB0: r = OP_BCS;
			8'hD0: r = OP_BNE;
			8'hF0: r = OP_BEQ;
			default: r = OP_ILL;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cpu6502_execute_unit.sv =====
// Top level of the 6502 execute unit: front-end decode queue and back-end executor.
//
// The slave stream carries one instruction per beat: opcode, fetched operand byte
// and the program counter after fetch. The master stream returns one result beat
// per instruction: new PC, branch flag, memory write-back, status and registers.
// An instruction is written into the decode queue at its accepting edge and is
// then executed from the queue into the output register, from which its result
// beat is presented; execution waits while the output holds an unaccepted beat.
// Throughput is one instruction per cycle while the receiver takes results; the
// executor's update of A, X, Y, SP and P with each executed instruction sets it.
// Reset empties the queue, clears the output valid and loads A, X, Y with zero,
// SP with 0xFD and P with 0x24.
// When the receiver stalls, the result holds in the output register, the
// executor stops, and the two-entry queue keeps accepting until it is full.
// Back pressure then reaches s_axis_tready.
`default_nettype none
module cpu6502_execute_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// opcode[7:0], operand[15:8], next_pc[31:16]
	input  wire logic [31:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// new_pc[15:0], branch_taken[16], mem_write[17], mem_data[25:18], status[27:26],
	// acc_out[35:28], xreg_out[43:36], yreg_out[51:44], flags_out[59:52], zeros above
	output logic [63:0]      m_axis_tdata
);
	import c6502_pkg::*;

	logic      q_valid, q_ready;
	dec_beat_t q_beat;
	logic [15:0] new_pc;
	logic branch_taken, mem_write;
	logic [7:0] mem_data, acc_out, xreg_out, yreg_out, flags_out;
	logic [1:0] status;

	c6502_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_opcode(s_axis_tdata[7:0]), .in_operand(s_axis_tdata[15:8]),
		.in_next_pc(s_axis_tdata[31:16]),
		.q_valid, .q_ready, .q_beat
	);

	c6502_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_beat,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.new_pc, .branch_taken, .mem_write, .mem_data, .status,
		.acc_out, .xreg_out, .yreg_out, .flags_out
	);

	assign m_axis_tdata = {4'd0, flags_out, yreg_out, xreg_out, acc_out, status,
		mem_data, mem_write, branch_taken, new_pc};
endmodule
`default_nettype wire

// ===== rtl/c6502_front.sv =====
// Front end: accepts instruction beats and decodes the opcode into a two-entry queue.
`default_nettype none
module c6502_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           in_opcode,
	input  wire logic [7:0]           in_operand,
	input  wire logic [15:0]          in_next_pc,
	output logic                      q_valid,
	input  wire logic                 q_ready,
	output c6502_pkg::dec_beat_t      q_beat
);
	import c6502_pkg::*;

	dec_beat_t  mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_beat   = mem_q[rptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// Queue storage; decode happens on the way in.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= '{op: decode_op(in_opcode), operand: in_operand,
				next_pc: in_next_pc};
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/c6502_back.sv =====
// Back end: executes decoded instructions against the register file and registers the result.
`default_nettype none
module c6502_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	output logic                      q_ready,
	input  wire c6502_pkg::dec_beat_t q_beat,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [15:0]               new_pc,
	output logic                      branch_taken,
	output logic                      mem_write,
	output logic [7:0]                mem_data,
	output logic [1:0]                status,
	output logic [7:0]                acc_out,
	output logic [7:0]                xreg_out,
	output logic [7:0]                yreg_out,
	output logic [7:0]                flags_out
);
	import c6502_pkg::*;

	logic [7:0] a_q, x_q, y_q, sp_q, p_q;
	logic [7:0] a_n, x_n, y_n, sp_n, p_n;
	logic [15:0] pc_n;
	logic taken_n, wr_n;
	logic [7:0] md_n;
	logic [1:0] st_n;
	logic fire;
	logic [7:0] v, r, addv;
	logic [8:0] sum;
	logic cond;

	assign q_ready = !out_valid || out_ready;
	assign fire    = q_valid && q_ready;
	assign v       = q_beat.operand;

	// Execute one instruction.
	always_comb begin
		a_n = a_q; x_n = x_q; y_n = y_q; sp_n = sp_q; p_n = p_q;
		pc_n = q_beat.next_pc; taken_n = 1'b0; wr_n = 1'b0; md_n = 8'd0;
		st_n = ST_DONE; r = 8'd0; cond = 1'b0;
		addv = (q_beat.op == OP_SBC) ? ~v : v;
		sum = {1'b0, a_q} + {1'b0, addv} + {8'd0, p_q[0]};
		unique case (q_beat.op)
			OP_ILL: st_n = ST_ILLEGAL;
			OP_SYS: st_n = ST_SYSTEM;
			OP_NOP: ;
			OP_ORA: begin r = a_q | v; a_n = r; end
			OP_AND: begin r = a_q & v; a_n = r; end
			OP_EOR: begin r = a_q ^ v; a_n = r; end
			OP_ADC, OP_SBC: begin
				r = sum[7:0]; a_n = r; p_n[0] = sum[8];
				p_n[6] = ~(a_q[7] ^ addv[7]) & (a_q[7] ^ r[7]);
			end
			OP_CMP: begin r = a_q - v; p_n[0] = (a_q >= v); end
			OP_CPX: begin r = x_q - v; p_n[0] = (x_q >= v); end
			OP_CPY: begin r = y_q - v; p_n[0] = (y_q >= v); end
			OP_BIT: ;
			OP_LDA: begin r = v; a_n = r; end
			OP_LDX: begin r = v; x_n = r; end
			OP_LDY: begin r = v; y_n = r; end
			OP_STA: begin wr_n = 1'b1; md_n = a_q; end
			OP_STX: begin wr_n = 1'b1; md_n = x_q; end
			OP_STY: begin wr_n = 1'b1; md_n = y_q; end
			OP_ASL: begin r = {v[6:0], 1'b0}; p_n[0] = v[7]; wr_n = 1'b1; md_n = r; end
			OP_LSR: begin r = {1'b0, v[7:1]}; p_n[0] = v[0]; wr_n = 1'b1; md_n = r; end
			OP_ROL: begin r = {v[6:0], p_q[0]}; p_n[0] = v[7]; wr_n = 1'b1; md_n = r; end
			OP_ROR: begin r = {p_q[0], v[7:1]}; p_n[0] = v[0]; wr_n = 1'b1; md_n = r; end
			OP_ASLA: begin r = {a_q[6:0], 1'b0}; p_n[0] = a_q[7]; a_n = r; end
			OP_LSRA: begin r = {1'b0, a_q[7:1]}; p_n[0] = a_q[0]; a_n = r; end
			OP_ROLA: begin r = {a_q[6:0], p_q[0]}; p_n[0] = a_q[7]; a_n = r; end
			OP_RORA: begin r = {p_q[0], a_q[7:1]}; p_n[0] = a_q[0]; a_n = r; end
			OP_INC: begin r = v + 8'd1; wr_n = 1'b1; md_n = r; end
			OP_DEC: begin r = v - 8'd1; wr_n = 1'b1; md_n = r; end
			OP_INX: begin r = x_q + 8'd1; x_n = r; end
			OP_INY: begin r = y_q + 8'd1; y_n = r; end
			OP_DEX: begin r = x_q - 8'd1; x_n = r; end
			OP_DEY: begin r = y_q - 8'd1; y_n = r; end
			OP_TAX: begin r = a_q; x_n = r; end
			OP_TAY: begin r = a_q; y_n = r; end
			OP_TXA: begin r = x_q; a_n = r; end
			OP_TYA: begin r = y_q; a_n = r; end
			OP_TSX: begin r = sp_q; x_n = r; end
			OP_TXS: sp_n = x_q;
			OP_CLC: p_n[0] = 1'b0;
			OP_SEC: p_n[0] = 1'b1;
			OP_CLI: p_n[2] = 1'b0;
			OP_SEI: p_n[2] = 1'b1;
			OP_CLV: p_n[6] = 1'b0;
			OP_CLD: p_n[3] = 1'b0;
			OP_SED: p_n[3] = 1'b1;
			OP_BPL: cond = !p_q[7];
			OP_BMI: cond = p_q[7];
			OP_BVC: cond = !p_q[6];
			OP_BVS: cond = p_q[6];
			OP_BCC: cond = !p_q[0];
			OP_BCS: cond = p_q[0];
			OP_BNE: cond = !p_q[1];
			OP_BEQ: cond = p_q[1];
			default: st_n = ST_ILLEGAL;
		endcase
		// N and Z follow the result for every op that produces one.
		case (q_beat.op) inside
			OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_SBC, OP_CMP, OP_CPX, OP_CPY,
			OP_LDA, OP_LDX, OP_LDY, [OP_ASL:OP_RORA], [OP_INC:OP_TSX]: begin
				p_n[7] = r[7];
				p_n[1] = (r == 8'd0);
			end
			OP_BIT: begin
				p_n[7] = v[7];
				p_n[6] = v[6];
				p_n[1] = ((v & a_q) == 8'd0);
			end
			default: ;
		endcase
		// Relative branch target.
		if (cond) begin
			taken_n = 1'b1;
			pc_n = q_beat.next_pc + {{8{v[7]}}, v};
		end
	end

	// Architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0;
			sp_q <= SP_RESET; p_q <= FLAGS_RESET;
			out_valid <= 1'b0;
		end else begin
			if (fire) begin
				a_q <= a_n; x_q <= x_n; y_q <= y_n; sp_q <= sp_n; p_q <= p_n;
			end
			if (fire) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (fire) begin
			new_pc <= pc_n; branch_taken <= taken_n; mem_write <= wr_n;
			mem_data <= md_n; status <= st_n; acc_out <= a_n; xreg_out <= x_n;
			yreg_out <= y_n; flags_out <= p_n;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/c6502_checker.sv =====
// Port-level checker for the 6502 execute unit and its bind statement.
`default_nettype none
module c6502_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [63:0] m_axis_tdata
);
	// A stalled result beat holds its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// Flag bit 5 always reads as one.
	a_flag5: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[57])
		else $error("flag bit 5 cleared");

	// Status never takes the unused code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[27] && m_axis_tdata[26]))
		else $error("bad status code");

	// Failed ops produce neither a write-back nor a taken branch, and leave mem_data zero.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[27:26] != 2'd0) |->
		!m_axis_tdata[17] && !m_axis_tdata[16] && (m_axis_tdata[25:18] == 8'd0))
		else $error("failed op produced side effects");

	// An accepted beat with a free output yields a result via the queue and the output register.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
		else $error("result missing");
endmodule

bind cpu6502_execute_unit c6502_checker u_checker (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
